FILE: hdl/room_free_list_allocator_top_assert.svh
// assertion macros for the room free list allocator
`ifndef ROOM_FREE_LIST_ALLOCATOR_TOP_ASSERT_SVH
`define ROOM_FREE_LIST_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define RFLA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define RFLA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/rfla_pkg.sv
// shared types and constants of the room free list allocator
`timescale 1ns / 1ps

package rfla_pkg;

    // field widths
    localparam int ID_W   = 10;
    localparam int ROOM_W = 11;

    // number of distinct guest indexes the id field can carry
    localparam int GUEST_SPAN = 1 << ID_W;

    // highest room number the room field can hold
    localparam int ROOM_MAX = (1 << ROOM_W) - 1;

    // default guest table size
    localparam int MAX_GUESTS_DEF = 1024;

    // event kind
    typedef enum logic {
        OP_ARRIVE = 1'b0,
        OP_DEPART = 1'b1
    } op_t;

    // result status
    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_NO_ROOM = 2'd1,
        STATUS_SEATED  = 2'd2
    } status_t;

    // free stack command
    typedef struct packed {
        logic push;
        logic pop;
    } stack_op_t;

    // free stack status
    typedef struct packed {
        logic empty;
        logic full;
    } stack_stat_t;

endpackage

FILE: hdl/room_free_list_allocator_top.sv
// top level of the room free list allocator
//
//  group  dir  tdata bits (low first)                    tuser bits (low first)
//  s_*    in   guest_id[9:0], zero pad to 16             operation[0]
//  m_*    out  room[10:0], rooms_opened_total[21:11],    fresh_room[0], status[2:1]
//              zero pad to 24
//
// each event is handled by a read of the guest table ram, followed by a resolve
// step that writes the table back and moves the free stack cells.
// after reset a clearing pass zeroes the guest table, one entry per cycle,
// covering min(MAX_GUESTS, 1024) entries (1024 by default), with s_tready low.
// a new word is taken while the previous result waits in the output register;
// the resolve cycle waits only while that register is still full.
`timescale 1ns / 1ps

module room_free_list_allocator_top #(
    parameter int MAX_GUESTS = rfla_pkg::MAX_GUESTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // guest_id[9:0], zero pad
    input  logic [0:0]  s_tuser,   // operation[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // room[10:0], rooms_opened_total[21:11], zero pad
    output logic [2:0]  m_tuser    // fresh_room[0], status[2:1]
);

    `include "room_free_list_allocator_top_assert.svh"

    localparam int ID_W   = rfla_pkg::ID_W;
    localparam int ROOM_W = rfla_pkg::ROOM_W;

    // guest table only needs the indexes the id field can reach
    localparam int GDEPTH = (MAX_GUESTS < rfla_pkg::GUEST_SPAN) ?
                            MAX_GUESTS : rfla_pkg::GUEST_SPAN;
    localparam int GIW    = $clog2(GDEPTH);
    localparam int STEPS  = ID_W - GIW + 1;

    // rooms that may ever be opened, which also bounds the free stack
    localparam int OPEN_LIMIT = (MAX_GUESTS < rfla_pkg::ROOM_MAX) ?
                                MAX_GUESTS : rfla_pkg::ROOM_MAX;

    localparam logic [ID_W:0]   GDEPTH_W     = (ID_W + 1)'(GDEPTH);
    localparam logic [ROOM_W-1:0] OPEN_LIMIT_W = ROOM_W'(OPEN_LIMIT);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic [GIW-1:0]        clr_cnt_reg;
    logic [GIW-1:0]        guest_reg;
    rfla_pkg::op_t         op_reg;
    logic [ROOM_W-1:0]     opened_reg;
    logic [ROOM_W-1:0]     opened_next;

    logic                  out_valid_reg;
    logic [ROOM_W-1:0]     out_room_reg;
    logic                  out_fresh_reg;
    logic [ROOM_W-1:0]     out_total_reg;
    rfla_pkg::status_t     out_status_reg;

    logic                  accept;
    logic                  exec_go;
    logic [ID_W:0]         rem;
    logic [GIW-1:0]        guest_idx;
    logic [ROOM_W-1:0]     held_room;

    logic                  tbl_we;
    logic [GIW-1:0]        tbl_waddr;
    logic [ROOM_W-1:0]     tbl_wdata;

    rfla_pkg::stack_op_t   stk_op;
    rfla_pkg::stack_op_t   stk_op_go;
    rfla_pkg::stack_stat_t stk_stat;
    logic [ROOM_W-1:0]     stk_top;

    logic [ROOM_W-1:0]     res_room;
    logic                  res_fresh;
    rfla_pkg::status_t     res_status;
    logic                  res_wr;
    logic [ROOM_W-1:0]     res_wdata;

    // handshakes
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign exec_go  = (state_reg == ST_EXEC) && (!out_valid_reg || m_tready);

    // fold the guest id into the table range by conditional subtraction
    always_comb
    begin
        rem = {1'b0, s_tdata[ID_W-1:0]};
        for (int k = STEPS - 1; k >= 0; k--)
        begin
            if (rem >= (GDEPTH_W << k))
            begin
                rem = rem - (GDEPTH_W << k);
            end
        end
        guest_idx = rem[GIW-1:0];
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == GIW'(GDEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + GIW'(1);
            end
        end
    end

    // event capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            guest_reg <= guest_idx;
            op_reg    <= rfla_pkg::op_t'(s_tuser[0]);
        end
    end

    // resolve one event from the guest's recorded room
    always_comb
    begin
        res_room    = '0;
        res_fresh   = 1'b0;
        res_status  = rfla_pkg::STATUS_OK;
        res_wr      = 1'b0;
        res_wdata   = '0;
        stk_op      = '0;
        opened_next = opened_reg;
        unique case (op_reg)
            rfla_pkg::OP_ARRIVE:
            begin
                priority if (held_room != '0)
                begin
                    res_status = rfla_pkg::STATUS_SEATED;
                end
                else if (!stk_stat.empty)
                begin
                    stk_op.pop = 1'b1;
                    res_room   = stk_top;
                    res_wr     = 1'b1;
                    res_wdata  = stk_top;
                end
                else if (opened_reg < OPEN_LIMIT_W)
                begin
                    opened_next = opened_reg + ROOM_W'(1);
                    res_room    = opened_next;
                    res_fresh   = 1'b1;
                    res_wr      = 1'b1;
                    res_wdata   = opened_next;
                end
                else
                begin
                    res_status = rfla_pkg::STATUS_SEATED;
                end
            end
            rfla_pkg::OP_DEPART:
            begin
                if (held_room == '0)
                begin
                    res_status = rfla_pkg::STATUS_NO_ROOM;
                end
                else
                begin
                    res_room    = held_room;
                    res_wr      = 1'b1;
                    res_wdata   = '0;
                    stk_op.push = 1'b1;
                end
            end
            default:
            begin
                res_status = rfla_pkg::STATUS_OK;
            end
        endcase
    end

    assign stk_op_go = exec_go ? stk_op : '0;

    // guest table write: clearing pass or event write-back
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            tbl_we    = 1'b1;
            tbl_waddr = clr_cnt_reg;
            tbl_wdata = '0;
        end
        else
        begin
            tbl_we    = exec_go && res_wr;
            tbl_waddr = guest_reg;
            tbl_wdata = res_wdata;
        end
    end

    rfla_ram #(
        .WIDTH (ROOM_W),
        .DEPTH (GDEPTH)
    ) u_guest_tbl (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .re    (accept),
        .raddr (guest_idx),
        .rdata (held_room)
    );

    rfla_stack #(
        .DEPTH (OPEN_LIMIT)
    ) u_free_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (stk_op_go),
        .push_data (held_room),
        .top       (stk_top),
        .stat      (stk_stat)
    );

    // rooms opened so far
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opened_reg <= '0;
        end
        else if (exec_go)
        begin
            opened_reg <= opened_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (exec_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_go)
        begin
            out_room_reg   <= res_room;
            out_fresh_reg  <= res_fresh;
            out_total_reg  <= opened_next;
            out_status_reg <= res_status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_total_reg, out_room_reg};
    assign m_tuser  = {out_status_reg, out_fresh_reg};

    // checks
    `RFLA_ASSERT_NOW(a_no_accept_in_clear, state_reg == ST_CLEAR, !s_tready,
        "word accepted during table clearing pass")
    `RFLA_ASSERT_NEXT(a_accept_to_exec, accept, state_reg == ST_EXEC,
        "accepted word did not enter the resolve cycle")
    `RFLA_ASSERT_NOW(a_fresh_is_ok, m_tvalid && m_tuser[0],
        m_tuser[2:1] == rfla_pkg::STATUS_OK,
        "fresh room flagged on an error result")
    `RFLA_ASSERT_NOW(a_error_room_zero, m_tvalid && (m_tuser[2:1] != rfla_pkg::STATUS_OK),
        m_tdata[10:0] == '0,
        "error result carries a room number")

endmodule

FILE: hdl/rfla_ram.sv
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module rfla_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/rfla_stack_cell.sv
// one entry of the shifting free room stack
`timescale 1ns / 1ps

module rfla_stack_cell (
    input  logic                         clk,
    input  rfla_pkg::stack_op_t          op,
    input  logic [rfla_pkg::ROOM_W-1:0]  from_prev,
    input  logic [rfla_pkg::ROOM_W-1:0]  from_next,
    output logic [rfla_pkg::ROOM_W-1:0]  value
);

    logic [rfla_pkg::ROOM_W-1:0] value_reg;

    // push takes the entry above, pop takes the entry below, else hold
    always_ff @(posedge clk)
    begin
        priority if (op.push)
        begin
            value_reg <= from_prev;
        end
        else if (op.pop)
        begin
            value_reg <= from_next;
        end
        else
        begin
            value_reg <= value_reg;
        end
    end

    assign value = value_reg;

endmodule

FILE: hdl/rfla_stack.sv
// lifo of free rooms built as a chain of shifting cells
`timescale 1ns / 1ps

module rfla_stack #(
    parameter int DEPTH = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rfla_pkg::stack_op_t          op,
    input  logic [rfla_pkg::ROOM_W-1:0]  push_data,
    output logic [rfla_pkg::ROOM_W-1:0]  top,
    output rfla_pkg::stack_stat_t        stat
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]               count_reg;
    logic [CW-1:0]               count_next;
    rfla_pkg::stack_op_t         cell_op;
    logic [rfla_pkg::ROOM_W-1:0] cell_val [DEPTH];

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CW'(DEPTH));

    // a push onto a full stack is dropped, a pop of an empty one ignored
    always_comb
    begin
        cell_op.push = op.push && !stat.full;
        cell_op.pop  = op.pop && !op.push && !stat.empty;
        priority if (cell_op.push)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cell_op.pop)
        begin
            count_next = count_reg - CW'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    // fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // cell chain, top of stack at cell zero
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [rfla_pkg::ROOM_W-1:0] prev_val;
        logic [rfla_pkg::ROOM_W-1:0] next_val;

        if (i == 0)
        begin : g_first
            assign prev_val = push_data;
        end
        else
        begin : g_mid
            assign prev_val = cell_val[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign next_val = cell_val[i];
        end
        else
        begin : g_inner
            assign next_val = cell_val[i+1];
        end

        rfla_stack_cell u_cell (
            .clk       (clk),
            .op        (cell_op),
            .from_prev (prev_val),
            .from_next (next_val),
            .value     (cell_val[i])
        );
    end

    assign top = cell_val[0];

endmodule

FILE: bench/room_free_list_allocator_top_test.sv
// testbench for the room free list allocator: directed and random event streams checked against a predictor
`timescale 1ns / 1ps

module room_free_list_allocator_top_test;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 16;
    localparam int REPORT_MAX = 10;

    // one expected reply word, split into its fields
    typedef struct packed {
        logic [rfla_pkg::ROOM_W-1:0] room;
        logic                        fresh;
        logic [rfla_pkg::ROOM_W-1:0] opened;
        rfla_pkg::status_t           status;
    } desk_reply_t;

    // tracks guest seating, the free room stack and the replies still owed
    class room_ledger;
        logic [rfla_pkg::ROOM_W-1:0] room_of_guest [rfla_pkg::GUEST_SPAN];
        logic [rfla_pkg::ROOM_W-1:0] free_stack [rfla_pkg::GUEST_SPAN];
        int unsigned                 free_depth;
        int unsigned                 opened;
        desk_reply_t                 due_replies [$];
        int unsigned                 mismatches;

        function new();
            for (int i = 0; i < rfla_pkg::GUEST_SPAN; i++)
            begin
                room_of_guest[i] = '0;
                free_stack[i] = '0;
            end
            free_depth = 0;
            opened = 0;
            mismatches = 0;
        endfunction

        function int pending();
            return due_replies.size();
        endfunction

        // work out the reply to an accepted event and update seating
        function void note_event(rfla_pkg::op_t op, logic [rfla_pkg::ID_W-1:0] guest);
            desk_reply_t reply;
            reply.room = '0;
            reply.fresh = 1'b0;
            reply.status = rfla_pkg::STATUS_OK;
            if (op == rfla_pkg::OP_ARRIVE)
            begin
                if (room_of_guest[guest] != '0)
                    reply.status = rfla_pkg::STATUS_SEATED;
                else if (free_depth > 0 && free_depth <= rfla_pkg::GUEST_SPAN)
                begin
                    free_depth--;
                    reply.room = free_stack[free_depth];
                    room_of_guest[guest] = reply.room;
                end
                else if (opened < rfla_pkg::GUEST_SPAN && opened < rfla_pkg::ROOM_MAX)
                begin
                    opened++;
                    reply.room = rfla_pkg::ROOM_W'(opened);
                    reply.fresh = 1'b1;
                    room_of_guest[guest] = reply.room;
                end
                else
                    reply.status = rfla_pkg::STATUS_SEATED;
            end
            else
            begin
                if (room_of_guest[guest] == '0)
                    reply.status = rfla_pkg::STATUS_NO_ROOM;
                else
                begin
                    reply.room = room_of_guest[guest];
                    room_of_guest[guest] = '0;
                    if (free_depth < rfla_pkg::GUEST_SPAN)
                    begin
                        free_stack[free_depth] = reply.room;
                        free_depth++;
                    end
                end
            end
            reply.opened = rfla_pkg::ROOM_W'(opened);
            due_replies.insert(due_replies.size(), reply);
        endfunction

        // compare one reply word with the oldest expected reply
        function void check_reply(logic [23:0] data, logic [2:0] flags);
            desk_reply_t want;
            logic [rfla_pkg::ROOM_W-1:0] got_room;
            logic [rfla_pkg::ROOM_W-1:0] got_opened;
            logic                        got_fresh;
            logic [1:0]                  got_status;
            got_room = data[10:0];
            got_opened = data[21:11];
            got_fresh = flags[0];
            got_status = flags[2:1];
            if (due_replies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected reply: room %0d fresh %0d opened %0d status %0d",
                             got_room, got_fresh, got_opened, got_status);
                return;
            end
            want = due_replies.pop_front();
            if (got_room !== want.room || got_fresh !== want.fresh ||
                got_opened !== want.opened || got_status !== want.status)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("reply mismatch: expected room %0d fresh %0d opened %0d status %0d, %s",
                             want.room, want.fresh, want.opened, want.status,
                             $sformatf("got room %0d fresh %0d opened %0d status %0d",
                                       got_room, got_fresh, got_opened, got_status));
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;   // guest_id[9:0], zero pad
    logic [0:0]  s_tuser = '0;   // operation[0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // room[10:0], rooms_opened_total[21:11], zero pad
    logic [2:0]  m_tuser;        // fresh_room[0], status[2:1]

    room_ledger  ledger = new();
    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;
    int unsigned cycle_count = 0;

    // stimulus-side view of who holds a room
    int          seated [$];
    bit          is_seated [rfla_pkg::GUEST_SPAN];

    room_free_list_allocator_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // reply side: check accepted words, stall at random
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                ledger.check_reply(m_tdata, m_tuser);
            m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // offer one event word, with random idle cycles ahead of it
    task automatic send_word(input rfla_pkg::op_t op, input int guest);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= 16'(guest);
        s_tuser <= op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        ledger.note_event(op, rfla_pkg::ID_W'(guest));
    endtask

    // a guest index that holds no room
    function automatic int pick_vacant();
        int g;
        g = $urandom_range(0, rfla_pkg::GUEST_SPAN - 1);
        while (is_seated[g])
            g = $urandom_range(0, rfla_pkg::GUEST_SPAN - 1);
        return g;
    endfunction

    // main sequence
    initial
    begin
        int  phase_items [4];
        int  src_pcts [4];
        int  sink_pcts [4];
        int  g;
        int  k;
        bit  filling;
        bit  want_arrive;
        int  high_mark;
        int  low_mark;

        phase_items = '{1250, 200, 200, 200};
        src_pcts = '{0, 75, 0, 10};
        sink_pcts = '{0, 0, 75, 10};
        filling = 1'b1;
        high_mark = rfla_pkg::GUEST_SPAN;
        low_mark = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        for (int phase = 0; phase < 4; phase++)
        begin
            src_idle_pct = src_pcts[phase];
            sink_stall_pct = sink_pcts[phase];

            // directed: errors, fresh rooms, lifo reuse, extreme guest ids
            if (phase == 0)
            begin
                send_word(rfla_pkg::OP_DEPART, 0);
                send_word(rfla_pkg::OP_ARRIVE, 0);
                send_word(rfla_pkg::OP_ARRIVE, 1023);
                send_word(rfla_pkg::OP_ARRIVE, 0);
                send_word(rfla_pkg::OP_DEPART, 1023);
                send_word(rfla_pkg::OP_DEPART, 1023);
                send_word(rfla_pkg::OP_ARRIVE, 'h155);
                send_word(rfla_pkg::OP_ARRIVE, 'h2AA);
                send_word(rfla_pkg::OP_DEPART, 0);
                send_word(rfla_pkg::OP_DEPART, 'h155);
                send_word(rfla_pkg::OP_ARRIVE, 1023);
                send_word(rfla_pkg::OP_ARRIVE, 0);
                send_word(rfla_pkg::OP_ARRIVE, 1);
                send_word(rfla_pkg::OP_ARRIVE, 'h200);
                send_word(rfla_pkg::OP_DEPART, 'h2AA);
                send_word(rfla_pkg::OP_DEPART, 1023);
                send_word(rfla_pkg::OP_DEPART, 0);
                send_word(rfla_pkg::OP_DEPART, 1);
                send_word(rfla_pkg::OP_DEPART, 'h200);
            end

            // random: fill and drain waves of legal events, some bad events mixed in
            for (int n = 0; n < phase_items[phase]; n++)
            begin
                if (filling && seated.size() >= high_mark)
                begin
                    filling = 1'b0;
                    low_mark = $urandom_range(0, high_mark / 2);
                end
                else if (!filling && seated.size() <= low_mark)
                begin
                    filling = 1'b1;
                    high_mark = $urandom_range(low_mark + 1, low_mark + 400);
                    if (high_mark > rfla_pkg::GUEST_SPAN)
                        high_mark = rfla_pkg::GUEST_SPAN;
                end

                if ($urandom_range(0, 15) == 0)
                begin
                    if (seated.size() > 0 &&
                        ($urandom_range(0, 1) == 1 || seated.size() == rfla_pkg::GUEST_SPAN))
                        send_word(rfla_pkg::OP_ARRIVE,
                                  seated[$urandom_range(0, seated.size() - 1)]);
                    else
                        send_word(rfla_pkg::OP_DEPART, pick_vacant());
                end
                else
                begin
                    want_arrive = filling ? ($urandom_range(0, 31) != 0)
                                          : ($urandom_range(0, 7) == 0);
                    if (seated.size() == 0)
                        want_arrive = 1'b1;
                    if (seated.size() == rfla_pkg::GUEST_SPAN)
                        want_arrive = 1'b0;
                    if (want_arrive)
                    begin
                        g = pick_vacant();
                        is_seated[g] = 1'b1;
                        seated.insert(seated.size(), g);
                        send_word(rfla_pkg::OP_ARRIVE, g);
                    end
                    else
                    begin
                        k = $urandom_range(0, seated.size() - 1);
                        g = seated[k];
                        seated[k] = seated[seated.size() - 1];
                        seated.pop_back();
                        is_seated[g] = 1'b0;
                        send_word(rfla_pkg::OP_DEPART, g);
                    end
                end
            end

            // hold the sender until every reply is in
            s_tvalid <= 1'b0;
            while (ledger.pending() != 0)
                @(posedge clk);
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (ledger.mismatches == 0 && ledger.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
